// ----- sv/window_filter_3x3_core_defines.svh -----
// Assertion macros shared by the 3x3 window filter RTL.
`ifndef WINDOW_FILTER_3X3_CORE_DEFINES_SVH
`define WINDOW_FILTER_3X3_CORE_DEFINES_SVH

// Clocked check that is switched off while reset is applied.
`define WF3_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define WF3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/wf3_pkg.sv -----
// Types, constants and control structs for the 3x3 window filter.
package wf3_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int FRAC_BITS  = 4;
  localparam int TAPS       = 9;
  localparam int MODE_W     = 3;
  localparam int OUT_W      = PIXEL_BITS + FRAC_BITS;
  // Kernel sums stay at or below 16 * pixel maximum.
  localparam int SUM_W      = PIXEL_BITS + 4;
  localparam int SCALED_W   = SUM_W + FRAC_BITS;
  localparam int RECIP_SHIFT = SCALED_W;
  localparam int PROD_W     = SCALED_W + RECIP_SHIFT;

  localparam int DIV_MEAN = 9;
  localparam int DIV_WAVG = 10;
  localparam logic [RECIP_SHIFT-1:0] RECIP_MEAN =
    RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / DIV_MEAN);
  localparam logic [RECIP_SHIFT-1:0] RECIP_WAVG =
    RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / DIV_WAVG);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [TAPS-1:0]       window_t;
  typedef logic [OUT_W-1:0]      out_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN   = 3'd0,
    MODE_GAUSS  = 3'd1,
    MODE_WAVG   = 3'd2,
    MODE_MEDIAN = 3'd3,
    MODE_MAX    = 3'd4,
    MODE_MIN    = 3'd5
  } filt_mode_t;

  typedef struct packed {
    logic       vld;
    filt_mode_t mode;
  } ctl_t;

  typedef struct packed {
    pix_t med;
    pix_t mn;
    pix_t mx;
  } rank_res_t;

endpackage

// ----- sv/wf3_sum_lane.sv -----
// Kernel-sum lane: mean, weighted average and gaussian, with reciprocal division.
module wf3_sum_lane (
  input  logic                clk,
  input  wf3_pkg::window_t    win,
  input  wf3_pkg::filt_mode_t mode_s1,
  output wf3_pkg::out_t       quot_val,
  output wf3_pkg::out_t       gauss_val
);
  import wf3_pkg::*;

  localparam int ROW_W = PIXEL_BITS + 2;
  localparam logic [SCALED_W-1:0] D_MEAN = SCALED_W'(DIV_MEAN);
  localparam logic [SCALED_W-1:0] D_WAVG = SCALED_W'(DIV_WAVG);

  logic [ROW_W-1:0]       row_sum_r [3];
  logic [ROW_W-1:0]       g_row_r [3];
  pix_t                   ctr_r;
  logic [ROW_W-1:0]       row_sum_nxt [3];
  logic [ROW_W-1:0]       g_row_nxt [3];

  logic [SUM_W-1:0]       sum9;
  logic [SUM_W-1:0]       wavg;
  logic [SUM_W-1:0]       gsum;
  logic [SUM_W-1:0]       dividend;
  logic [SCALED_W-1:0]    x_nxt;
  logic [RECIP_SHIFT-1:0] recip_nxt;

  logic [SCALED_W-1:0]    x_s2_r;
  logic [RECIP_SHIFT-1:0] recip_s2_r;
  logic                   is_mean_s2_r;
  logic [SUM_W-1:0]       gauss_s2_r;

  logic [PROD_W-1:0]      prod_r;
  logic [SCALED_W-1:0]    x_s3_r;
  logic                   is_mean_s3_r;
  logic [SUM_W-1:0]       gauss_s3_r;

  logic [SCALED_W-1:0]    q;
  logic [SCALED_W-1:0]    d;
  logic [SCALED_W-1:0]    dq;
  logic [SCALED_W-1:0]    rem;
  logic [SCALED_W-1:0]    q_fix;

  // Stage 1: plain and 1-2-1 weighted sums of each row.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_sum_nxt[k] = ROW_W'(win[3*k]) + ROW_W'(win[3*k+1]) + ROW_W'(win[3*k+2]);
      g_row_nxt[k]   = ROW_W'(win[3*k]) + {1'b0, win[3*k+1], 1'b0} + ROW_W'(win[3*k+2]);
    end
  end

  always_ff @(posedge clk) begin
    row_sum_r <= row_sum_nxt;
    g_row_r   <= g_row_nxt;
    ctr_r     <= win[4];
  end

  // Stage 2: full kernel sums and choice of divisor.
  always_comb begin
    sum9     = SUM_W'(row_sum_r[0]) + SUM_W'(row_sum_r[1]) + SUM_W'(row_sum_r[2]);
    wavg     = sum9 + SUM_W'(ctr_r);
    gsum     = SUM_W'(g_row_r[0]) + SUM_W'({g_row_r[1], 1'b0}) + SUM_W'(g_row_r[2]);
    dividend = (mode_s1 == MODE_MEAN) ? sum9 : wavg;
    x_nxt    = {dividend, {FRAC_BITS{1'b0}}};
    recip_nxt = (mode_s1 == MODE_MEAN) ? RECIP_MEAN : RECIP_WAVG;
  end

  always_ff @(posedge clk) begin
    x_s2_r       <= x_nxt;
    recip_s2_r   <= recip_nxt;
    is_mean_s2_r <= (mode_s1 == MODE_MEAN);
    gauss_s2_r   <= gsum;
  end

  // Stage 3: multiply by the truncated reciprocal.
  always_ff @(posedge clk) begin
    prod_r       <= PROD_W'(x_s2_r) * PROD_W'(recip_s2_r);
    x_s3_r       <= x_s2_r;
    is_mean_s3_r <= is_mean_s2_r;
    gauss_s3_r   <= gauss_s2_r;
  end

  // The estimate is at most one below the true quotient, so one
  // compare and increment restores it.
  always_comb begin
    q     = prod_r[PROD_W-1 -: SCALED_W];
    d     = is_mean_s3_r ? D_MEAN : D_WAVG;
    dq    = SCALED_W'(q * d);
    rem   = x_s3_r - dq;
    q_fix = (rem >= d) ? q + SCALED_W'(1) : q;
  end

  assign quot_val  = OUT_W'(q_fix);
  assign gauss_val = OUT_W'(gauss_s3_r);

endmodule

// ----- sv/wf3_rank_lane.sv -----
// Rank lane: median, minimum and maximum of the nine pixels.
module wf3_rank_lane (
  input  logic               clk,
  input  wf3_pkg::window_t   win,
  output wf3_pkg::rank_res_t rank
);
  import wf3_pkg::*;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } tri_t;

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic tri_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t x0;
    pix_t x1;
    pix_t x2;
    pix_t t;
    tri_t r;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    r.lo  = x0;
    r.mid = x1;
    r.hi  = x2;
    return r;
  endfunction

  tri_t row_r [3];
  tri_t row_nxt [3];
  pix_t mn_r;
  pix_t mx_r;
  pix_t lo_max_r;
  pix_t mid_med_r;
  pix_t hi_min_r;
  rank_res_t rank_r;

  // Stage 1: sort each row.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_nxt[k] = sort3(win[3*k], win[3*k+1], win[3*k+2]);
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  // Stage 2: the median of nine is the median of the largest low,
  // the median middle and the smallest high.
  always_ff @(posedge clk) begin
    mn_r      <= min2(min2(row_r[0].lo, row_r[1].lo), row_r[2].lo);
    mx_r      <= max2(max2(row_r[0].hi, row_r[1].hi), row_r[2].hi);
    lo_max_r  <= max2(max2(row_r[0].lo, row_r[1].lo), row_r[2].lo);
    mid_med_r <= med3(row_r[0].mid, row_r[1].mid, row_r[2].mid);
    hi_min_r  <= min2(min2(row_r[0].hi, row_r[1].hi), row_r[2].hi);
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    rank_r.med <= med3(lo_max_r, mid_med_r, hi_min_r);
    rank_r.mn  <= mn_r;
    rank_r.mx  <= mx_r;
  end

  assign rank = rank_r;

endmodule

// ----- sv/wf3_merge.sv -----
// Merge stage: picks the lane result for the request's mode and registers it.
module wf3_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  wf3_pkg::ctl_t      ctl,
  input  wf3_pkg::out_t      quot_val,
  input  wf3_pkg::out_t      gauss_val,
  input  wf3_pkg::rank_res_t rank,
  output logic               strobe,
  output wf3_pkg::out_t      value
);
  import wf3_pkg::*;

  logic strobe_r;
  out_t value_r;
  out_t value_nxt;

  always_comb begin
    case (ctl.mode)
      MODE_MEAN:   value_nxt = quot_val;
      MODE_WAVG:   value_nxt = quot_val;
      MODE_GAUSS:  value_nxt = gauss_val;
      MODE_MEDIAN: value_nxt = {rank.med, {FRAC_BITS{1'b0}}};
      MODE_MAX:    value_nxt = {rank.mx, {FRAC_BITS{1'b0}}};
      MODE_MIN:    value_nxt = {rank.mn, {FRAC_BITS{1'b0}}};
      default:     value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign strobe = strobe_r;
  assign value  = value_r;

endmodule

// ----- sv/window_filter_3x3_core.sv -----
// Top level of the 3x3 window filter: lanes, control pipeline and mode register.
// A request taken at one edge passes the three lane stages and the merge register before
// out_strobe rises with its result. Throughput: one request per clock; busy is never
// raised and results cannot be held off. Synchronous active-low reset clears the pipeline
// valid bits and sets mean.
`include "window_filter_3x3_core_defines.svh"
module window_filter_3x3_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  wf3_pkg::pix_t         in_px_r0_c0,
  input  wf3_pkg::pix_t         in_px_r0_c1,
  input  wf3_pkg::pix_t         in_px_r0_c2,
  input  wf3_pkg::pix_t         in_px_r1_c0,
  input  wf3_pkg::pix_t         in_px_r1_c1,
  input  wf3_pkg::pix_t         in_px_r1_c2,
  input  wf3_pkg::pix_t         in_px_r2_c0,
  input  wf3_pkg::pix_t         in_px_r2_c1,
  input  wf3_pkg::pix_t         in_px_r2_c2,
  input  logic                  cfg_we,
  input  logic [wf3_pkg::MODE_W-1:0] cfg_data,
  output logic                  out_strobe,
  output wf3_pkg::out_t         out_filtered_value
);
  import wf3_pkg::*;

  filt_mode_t mode_r;
  ctl_t       ctl_r [3];
  window_t    win;
  logic       accept;
  out_t       quot_val;
  out_t       gauss_val;
  rank_res_t  rank;
  logic       rank_mode;
  logic       frac_zero;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign win = {in_px_r2_c2, in_px_r2_c1, in_px_r2_c0,
                in_px_r1_c2, in_px_r1_c1, in_px_r1_c0,
                in_px_r0_c2, in_px_r0_c1, in_px_r0_c0};

  assign rank_mode = (ctl_r[2].mode == MODE_MEDIAN) || (ctl_r[2].mode == MODE_MAX) ||
                     (ctl_r[2].mode == MODE_MIN);
  assign frac_zero = (out_filtered_value[FRAC_BITS-1:0] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MEAN;
    end else if (cfg_we) begin
      mode_r <= filt_mode_t'(cfg_data);
    end
  end

  // Each request carries the mode it was taken with down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
      ctl_r[1] <= '0;
      ctl_r[2] <= '0;
    end else begin
      ctl_r[0] <= '{vld: accept, mode: mode_r};
      ctl_r[1] <= ctl_r[0];
      ctl_r[2] <= ctl_r[1];
    end
  end

  wf3_sum_lane u_sum_lane (
    .clk       (clk),
    .win       (win),
    .mode_s1   (ctl_r[0].mode),
    .quot_val  (quot_val),
    .gauss_val (gauss_val)
  );

  wf3_rank_lane u_rank_lane (
    .clk  (clk),
    .win  (win),
    .rank (rank)
  );

  wf3_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_r[2]),
    .quot_val  (quot_val),
    .gauss_val (gauss_val),
    .rank      (rank),
    .strobe    (out_strobe),
    .value     (out_filtered_value)
  );

  `WF3_ASSERT_CLK(a_req_gives_result, accept |-> ##4 out_strobe, "request produced no result")
  `WF3_ASSERT_CLK(a_no_extra_result, !accept |-> ##4 !out_strobe, "result without a request")
  `WF3_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_strobe, "result strobe after reset")
  `WF3_ASSERT_CLK(a_rank_whole, out_strobe && $past(rank_mode) |-> frac_zero, "rank has fraction")

endmodule
